// ===== hw/rtl/hexn_pkg.sv =====
// ----------------------------------------------------------------------------
// hexn_pkg
// Shared types and constants for the offset-row hex grid neighbor generator.
// ----------------------------------------------------------------------------
package hexn_pkg;

  localparam int unsigned MAX_SIDE   = 1024;
  localparam int unsigned MAX_LAYERS = 256;
  localparam int unsigned NUM_SLOTS  = 6;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned LAYER_W = 8;
  localparam int unsigned SIDE_W  = 11;
  localparam int unsigned SLOT_W  = 3;
  // Signed working width: holds -3 .. 2*MAX_SIDE comfortably.
  localparam int unsigned CALC_W  = 13;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               present;
  } nbr_t;

endpackage

// ===== hw/rtl/hexn_nbr_calc.sv =====
// ----------------------------------------------------------------------------
// hexn_nbr_calc
// Combinational computation of the six neighbor cells of one center cell,
// including edge wrapping and the final in-grid check.
// ----------------------------------------------------------------------------
module hexn_nbr_calc (
  input  logic [hexn_pkg::COORD_W-1:0] col_i,
  input  logic [hexn_pkg::COORD_W-1:0] row_i,
  input  logic [hexn_pkg::LAYER_W-1:0] layer_i,
  input  logic [hexn_pkg::SIDE_W-1:0]  width_i,   // already clamped to 1..MAX_SIDE
  input  logic [hexn_pkg::SIDE_W-1:0]  height_i,  // already clamped to 1..MAX_SIDE
  input  logic                         wrap_i,
  output hexn_pkg::nbr_t               nbr_o [hexn_pkg::NUM_SLOTS]
);
  import hexn_pkg::*;

  logic signed [CALC_W-1:0] xs, ys, ws, hs;
  logic                     in_grid, even_h;
  logic                     left_ok, right_ok, down_ok, up_ok;
  logic signed [CALC_W-1:0] r0, r3, ru, rd, cl, cr;
  logic                     p0, p3, pu, pd, pl, pr;
  logic signed [CALC_W-1:0] cand_c [NUM_SLOTS];
  logic signed [CALC_W-1:0] cand_r [NUM_SLOTS];
  logic                     cand_p [NUM_SLOTS];

  assign xs = signed'(CALC_W'(col_i));
  assign ys = signed'(CALC_W'(row_i));
  assign ws = signed'(CALC_W'(width_i));
  assign hs = signed'(CALC_W'(height_i));

  assign in_grid  = (xs < ws) && (ys < hs) && ({1'b0, layer_i} < (LAYER_W+1)'(MAX_LAYERS));
  assign even_h   = ~height_i[0];
  assign left_ok  = (col_i != '0);
  assign right_ok = (xs + CALC_W'(1)) < ws;
  assign down_ok  = (row_i != '0);
  assign up_ok    = (ys + CALC_W'(1)) < hs;

  always_comb begin
    // Two rows down; a wrap lands on a row chosen by the height parity.
    p0 = 1'b1;
    r0 = '0;
    if (ys >= CALC_W'(2)) begin
      r0 = ys - CALC_W'(2);
    end else if (wrap_i) begin
      if (even_h) r0 = down_ok ? hs - CALC_W'(1) : hs - CALC_W'(2);
      else        r0 = down_ok ? hs - CALC_W'(2) : hs - CALC_W'(3);
    end else begin
      p0 = 1'b0;
    end

    // Two rows up.
    p3 = 1'b1;
    r3 = '0;
    if ((ys + CALC_W'(2)) < hs) begin
      r3 = ys + CALC_W'(2);
    end else if (wrap_i) begin
      if (even_h) r3 = up_ok ? CALC_W'(0) : CALC_W'(1);
      else        r3 = up_ok ? CALC_W'(1) : CALC_W'(2);
    end else begin
      p3 = 1'b0;
    end
  end

  assign pu = up_ok || wrap_i;
  assign ru = up_ok ? ys + CALC_W'(1) : '0;
  assign pd = down_ok || wrap_i;
  assign rd = down_ok ? ys - CALC_W'(1) : hs - CALC_W'(1);
  assign pr = right_ok || wrap_i;
  assign cr = right_ok ? xs + CALC_W'(1) : '0;
  assign pl = left_ok || wrap_i;
  assign cl = left_ok ? xs - CALC_W'(1) : ws - CALC_W'(1);

  always_comb begin
    cand_c[0] = xs;  cand_r[0] = r0;  cand_p[0] = in_grid && p0;
    cand_c[3] = xs;  cand_r[3] = r3;  cand_p[3] = in_grid && p3;
    if (row_i[0]) begin
      // Odd rows: diagonals sit at x and x+1.
      cand_c[5] = xs;  cand_r[5] = ru;  cand_p[5] = in_grid && pu;
      cand_c[1] = cr;  cand_r[1] = ru;  cand_p[1] = in_grid && pu && pr;
      cand_c[4] = xs;  cand_r[4] = rd;  cand_p[4] = in_grid && pd;
      cand_c[2] = cr;  cand_r[2] = rd;  cand_p[2] = in_grid && pd && pr;
    end else begin
      // Even rows: diagonals sit at x-1 and x.
      cand_c[1] = xs;  cand_r[1] = ru;  cand_p[1] = in_grid && pu;
      cand_c[5] = cl;  cand_r[5] = ru;  cand_p[5] = in_grid && pu && pl;
      cand_c[2] = xs;  cand_r[2] = rd;  cand_p[2] = in_grid && pd;
      cand_c[4] = cl;  cand_r[4] = rd;  cand_p[4] = in_grid && pd && pl;
    end
  end

  // A wrapped row can still fall outside a very small grid; such a
  // neighbor is reported absent.
  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    logic ok;
    assign ok = cand_p[s] &&
                (cand_c[s] >= CALC_W'(0)) && (cand_c[s] < ws) &&
                (cand_r[s] >= CALC_W'(0)) && (cand_r[s] < hs);
    assign nbr_o[s].present = ok;
    assign nbr_o[s].col     = ok ? cand_c[s][COORD_W-1:0] : '0;
    assign nbr_o[s].row     = ok ? cand_r[s][COORD_W-1:0] : '0;
  end

endmodule

// ===== hw/rtl/hex_grid_neighbor_generator_core.sv =====
// ----------------------------------------------------------------------------
// hex_grid_neighbor_generator_core
// Emits the six neighbor cells of each center cell of an offset-row hex grid.
// ----------------------------------------------------------------------------
//  Channel   Direction  Request content
//  s_axis    in         one center cell (col, row, layer)
//  m_axis    out        one neighbor per request, slots 0..5, tlast on slot 5
//  cfg       in         register write: width, height, wrap enable
//
// Each center cell produces six output requests, one per cycle while m_axis is
// ready; the output bank serializer drains them. An input stage takes the next
// center cell while the current six are drained. Reset empties both stages and
// restores the default 1024 x 1024 grid without wrapping. A stall on m_axis
// holds the current neighbor; s_axis backs up once the input stage is full.
// ----------------------------------------------------------------------------
module hex_grid_neighbor_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [hexn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hexn_pkg::SIDE_W-1:0]      cfg_data_i,
  // Center cell stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,   // col[9:0], row[19:10],
                                                           // layer[27:20], zeros
  // Neighbor stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,   // slot[2:0], neighbor_col[12:3],
                                                           // neighbor_row[22:13],
                                                           // neighbor_layer[30:23], zero
  output logic                             m_axis_tuser,   // present
  output logic                             m_axis_tlast
);
  import hexn_pkg::*;

  // Clamp a side length to 1..MAX_SIDE.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  logic [SIDE_W-1:0]  width_q, height_q;
  logic               wrap_q;

  logic               a_valid_q;
  logic [COORD_W-1:0] a_col_q, a_row_q;
  logic [LAYER_W-1:0] a_layer_q;

  logic               b_valid_q;
  logic [SLOT_W-1:0]  cnt_q;
  logic [LAYER_W-1:0] b_layer_q;
  nbr_t               bank_q [NUM_SLOTS];

  nbr_t               calc_nbr [NUM_SLOTS];
  logic               s_fire, m_fire, b_done, load_b;
  nbr_t               cur;

  // Configuration registers hold the clamped values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_W'(MAX_SIDE);
      height_q <= SIDE_W'(MAX_SIDE);
      wrap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH:  width_q  <= clamp_side(cfg_data_i);
        CFG_GRID_HEIGHT: height_q <= clamp_side(cfg_data_i);
        CFG_WRAP_ENABLE: wrap_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign b_done        = m_fire && (cnt_q == LAST_SLOT);
  assign load_b        = a_valid_q && (!b_valid_q || b_done);
  assign s_axis_tready = !a_valid_q || load_b;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_fire) begin
      a_valid_q <= 1'b1;
    end else if (load_b) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_col_q   <= s_axis_tdata[COORD_W-1:0];
      a_row_q   <= s_axis_tdata[2*COORD_W-1:COORD_W];
      a_layer_q <= s_axis_tdata[2*COORD_W+LAYER_W-1:2*COORD_W];
    end
  end

  hexn_nbr_calc u_calc (
    .col_i    (a_col_q),
    .row_i    (a_row_q),
    .layer_i  (a_layer_q),
    .width_i  (width_q),
    .height_i (height_q),
    .wrap_i   (wrap_q),
    .nbr_o    (calc_nbr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else if (load_b) begin
      b_valid_q <= 1'b1;
      cnt_q     <= '0;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else if (m_fire) begin
      cnt_q     <= cnt_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      bank_q    <= calc_nbr;
      b_layer_q <= a_layer_q;
    end
  end

  assign cur           = bank_q[cnt_q];
  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tdata  = {1'b0, b_layer_q, cur.row, cur.col, cnt_q};
  assign m_axis_tuser  = cur.present;
  assign m_axis_tlast  = (cnt_q == LAST_SLOT);

endmodule

// ===== dv/hex_grid_neighbor_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_grid_neighbor_generator_core_tb
// Sends center cells into the neighbor generator under a range of grid sizes,
// wrap settings and backpressure patterns. Every accepted center cell is
// turned into its six expected neighbors, which are compared in order with
// the neighbor stream.
// ----------------------------------------------------------------------------
module hex_grid_neighbor_generator_core_tb;
  import hexn_pkg::*;

  // Direction slots in emission order.
  localparam int SLOT_DOWN2  = 0;
  localparam int SLOT_UP_R   = 1;
  localparam int SLOT_DOWN_R = 2;
  localparam int SLOT_UP2    = 3;
  localparam int SLOT_DOWN_L = 4;
  localparam int SLOT_UP_L   = 5;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [LAYER_W-1:0] layer;
    logic               present;
    logic               last;
  } neighbor_t;

  class hex_ring_tracker;
    logic [SIDE_W-1:0] grid_width  = 11'd1024;
    logic [SIDE_W-1:0] grid_height = 11'd1024;
    bit                wrap_enable = 1'b0;
    neighbor_t         pending_neighbors[$];
    int                mismatches  = 0;

    static function int side_of(logic [SIDE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return int'(v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
      case (idx)
        CFG_GRID_WIDTH: begin
          grid_width = val;
        end
        CFG_GRID_HEIGHT: begin
          grid_height = val;
        end
        CFG_WRAP_ENABLE: begin
          wrap_enable = val[0];
        end
        default: begin
        end
      endcase
    endfunction

    function neighbor_t place(int s, bit ok, int c, int r, int lay, int w, int h);
      neighbor_t n;
      if (ok && (c < 0 || c >= w || r < 0 || r >= h)) ok = 1'b0;
      n.slot    = s[SLOT_W-1:0];
      n.col     = ok ? c[COORD_W-1:0] : '0;
      n.row     = ok ? r[COORD_W-1:0] : '0;
      n.layer   = lay[LAYER_W-1:0];
      n.present = ok;
      n.last    = (s[SLOT_W-1:0] == LAST_SLOT);
      return n;
    endfunction

    // Works out the six neighbors of an accepted center cell.
    function void note_center(int x, int y, int lay);
      neighbor_t ring[NUM_SLOTS];
      int  w, h, r0, r3, ru, rd, cl, cr;
      bit  wr, in_grid, even_h, left_ok, right_ok, down_ok, up_ok;
      bit  p0, p3, pu, pd, pl, pr;
      w        = side_of(grid_width);
      h        = side_of(grid_height);
      wr       = wrap_enable;
      in_grid  = (x < w) && (y < h) && (lay < MAX_LAYERS);
      even_h   = (h % 2) == 0;
      left_ok  = x - 1 >= 0;
      right_ok = x + 1 < w;
      down_ok  = y - 1 >= 0;
      up_ok    = y + 1 < h;
      r0 = 0;
      r3 = 0;
      // A two-row wrap lands on a row picked by height parity; for tiny grids
      // the target can fall outside and place() then marks it absent.
      p0 = 1'b1;
      if (y - 2 >= 0) r0 = y - 2;
      else if (wr) r0 = even_h ? (down_ok ? h - 1 : h - 2) : (down_ok ? h - 2 : h - 3);
      else p0 = 1'b0;
      p3 = 1'b1;
      if (y + 2 < h) r3 = y + 2;
      else if (wr) r3 = even_h ? (up_ok ? 0 : 1) : (up_ok ? 1 : 2);
      else p3 = 1'b0;
      pu = up_ok || wr;
      ru = up_ok ? y + 1 : 0;
      pd = down_ok || wr;
      rd = down_ok ? y - 1 : h - 1;
      pr = right_ok || wr;
      cr = right_ok ? x + 1 : 0;
      pl = left_ok || wr;
      cl = left_ok ? x - 1 : w - 1;
      ring[SLOT_DOWN2] = place(SLOT_DOWN2, in_grid && p0, x, r0, lay, w, h);
      ring[SLOT_UP2]   = place(SLOT_UP2, in_grid && p3, x, r3, lay, w, h);
      if (y % 2 == 1) begin
        ring[SLOT_UP_L]   = place(SLOT_UP_L, in_grid && pu, x, ru, lay, w, h);
        ring[SLOT_UP_R]   = place(SLOT_UP_R, in_grid && pu && pr, cr, ru, lay, w, h);
        ring[SLOT_DOWN_L] = place(SLOT_DOWN_L, in_grid && pd, x, rd, lay, w, h);
        ring[SLOT_DOWN_R] = place(SLOT_DOWN_R, in_grid && pd && pr, cr, rd, lay, w, h);
      end else begin
        ring[SLOT_UP_R]   = place(SLOT_UP_R, in_grid && pu, x, ru, lay, w, h);
        ring[SLOT_UP_L]   = place(SLOT_UP_L, in_grid && pu && pl, cl, ru, lay, w, h);
        ring[SLOT_DOWN_R] = place(SLOT_DOWN_R, in_grid && pd, x, rd, lay, w, h);
        ring[SLOT_DOWN_L] = place(SLOT_DOWN_L, in_grid && pd && pl, cl, rd, lay, w, h);
      end
      foreach (ring[i]) pending_neighbors.push_back(ring[i]);
    endfunction

    function void compare(string field, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_neighbor(logic [31:0] data, logic present, logic last);
      neighbor_t e;
      if (pending_neighbors.size() == 0) begin
        $error("neighbor with none pending: tdata %h", data);
        mismatches++;
        return;
      end
      e = pending_neighbors.pop_front();
      compare("slot", e.slot, data[2:0]);
      compare("neighbor_col", e.col, data[12:3]);
      compare("neighbor_row", e.row, data[22:13]);
      compare("neighbor_layer", e.layer, data[30:23]);
      compare("present", e.present, present);
      compare("last", e.last, last);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIDE_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [31:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  hex_ring_tracker tracker = new();
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;

  hex_grid_neighbor_generator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Neighbor sink: checks each accepted request and picks the next ready.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        tracker.check_neighbor(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 66;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct  = 25;
        recv_stall_pct = 25;
      end
    endcase
  endtask

  task automatic send_cell(int col, int row, int lay);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, lay[LAYER_W-1:0], row[COORD_W-1:0], col[COORD_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_center(col, row, lay);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_neighbors.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_grid(int w, int h, bit wrap);
    write_reg(CFG_GRID_WIDTH, w[SIDE_W-1:0]);
    write_reg(CFG_GRID_HEIGHT, h[SIDE_W-1:0]);
    write_reg(CFG_WRAP_ENABLE, {10'b0, wrap});
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-grid coordinates with a bias toward the edges, some outside.
  function automatic int pick_coord(int side);
    int r, e;
    r = $urandom_range(99);
    e = $urandom_range(2);
    if (r < 12) return $urandom_range(1023);
    if (r < 45) begin
      if ($urandom_range(1)) return (e < side) ? e : side - 1;
      return (side - 1 - e >= 0) ? side - 1 - e : 0;
    end
    return $urandom_range(side - 1);
  endfunction

  initial begin
    int w_tab[10]    = '{1024, 8, 7, 1, 2, 100, 1500, 33, 0, 640};
    int h_tab[10]    = '{1024, 6, 9, 1, 4, 37, 1023, 2, 5, 3};
    bit wrap_tab[10] = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1};
    int w, h;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_GRID_WIDTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset grid: full 1024 x 1024 without wrapping, field extremes.
    set_idling(0);
    send_cell(0, 0, 0);
    send_cell(1023, 1023, 255);
    send_cell(1023, 0, 1);
    send_cell(0, 1023, 128);
    send_cell(512, 513, 8'hAA);
    send_cell(5, 6, 8'h55);

    // Odd height with wrapping: both two-row wrap variants, column wrap,
    // and centers outside the grid.
    drain();
    set_grid(5, 7, 1'b1);
    set_idling(1);
    send_cell(0, 0, 3);
    send_cell(4, 1, 4);
    send_cell(0, 5, 5);
    send_cell(4, 6, 6);
    send_cell(2, 3, 7);
    send_cell(5, 2, 8);
    send_cell(2, 7, 9);
    send_cell(1023, 1023, 10);

    // Out-of-range registers: width above the maximum, height of zero.
    drain();
    set_grid(2047, 0, 1'b1);
    set_idling(2);
    send_cell(0, 0, 11);
    send_cell(1023, 0, 12);
    send_cell(0, 1, 13);

    // Tiny even height: the two-row wraps land back on the center's own row.
    drain();
    set_grid(3, 2, 1'b1);
    set_idling(3);
    send_cell(0, 0, 14);
    send_cell(2, 1, 15);

    // Tiny odd height on a single column; a write to the spare index too.
    drain();
    write_reg(CFG_SPARE, 11'h5A5);
    set_grid(1, 3, 1'b1);
    set_idling(0);
    send_cell(0, 0, 16);
    send_cell(0, 1, 17);
    send_cell(0, 2, 18);

    for (int p = 0; p < 10; p++) begin
      drain();
      set_grid(w_tab[p], h_tab[p], wrap_tab[p]);
      set_idling(p % 4);
      w = hex_ring_tracker::side_of(w_tab[p]);
      h = hex_ring_tracker::side_of(h_tab[p]);
      repeat (45) send_cell(pick_coord(w), pick_coord(h), $urandom_range(255));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_neighbors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
